FILE: src/hpt_pkg.sv
// shared types and constants for the homogeneous point transform
package hpt_pkg;

    // default fraction bits of every coordinate and matrix element
    localparam int FRAC_BITS = 16;

    // quotient bits produced by the divider, one per pipeline stage
    localparam int DIV_STEPS = 32;

    // configuration register file
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 64;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_zero;
        logic               saturated;
    } out_t;

endpackage

FILE: src/homogeneous_point_transform_top.sv
// homogeneous 4x4 point transform with perspective divide, fully pipelined
// an input passes the product, row-sum, divider setup and divider stages, then the output register
// throughput: one point per cycle while the output is not stalled, set by the single-step divider stages
// a stall at the output freezes the whole pipeline, nothing lost or repeated
// reset: all valid bits cleared, matrix loaded with the identity
// divider uses one restoring subtract per stage, three lanes share the w operand
module homogeneous_point_transform_top #(
    parameter int FRAC_BITS = hpt_pkg::FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hpt_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hpt_pkg::out_t                 out_data,
    input  logic                          cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hpt_pkg::CFG_W-1:0]     cfg_data
);

    localparam int NS   = hpt_pkg::DIV_STEPS;
    // dividend is |v| scaled by 2^FRAC_BITS
    localparam int NW   = 64 + FRAC_BITS;
    // upper part of the dividend, above its low 32 bits that seed the quotient register
    localparam int HW   = NW - 32;
    localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic [hpt_pkg::CFG_W-1:0] cfg_reg [hpt_pkg::NUM_CFG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity: diagonal at rows 0..3
            cfg_reg[0] <= ONE;
            cfg_reg[1] <= '0;
            cfg_reg[2] <= ONE << 32;
            cfg_reg[3] <= '0;
            cfg_reg[4] <= '0;
            cfg_reg[5] <= ONE;
            cfg_reg[6] <= '0;
            cfg_reg[7] <= ONE << 32;
        end
        else if (cfg_we && (cfg_index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_CFG)))
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // matrix element view: two elements per register
    logic signed [31:0] mat [4][4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            mat[r][0] = cfg_reg[2*r][31:0];
            mat[r][1] = cfg_reg[2*r][63:32];
            mat[r][2] = cfg_reg[2*r+1][31:0];
            mat[r][3] = cfg_reg[2*r+1][63:32];
        end
    end

    // ---------------- global pipeline advance ----------------
    // every stage moves together; the output register holds on a stall
    logic out_valid_reg;
    logic en;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: twelve products ----------------
    logic               v1_reg;
    logic signed [63:0] prod_reg [4][3];
    logic signed [31:0] m3_reg   [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                prod_reg[r][0] <= mat[r][0] * in_data.in_x;
                prod_reg[r][1] <= mat[r][1] * in_data.in_y;
                prod_reg[r][2] <= mat[r][2] * in_data.in_z;
                m3_reg[r]      <= mat[r][3];
            end
        end
    end

    // ---------------- stage 2: row sums, floored, plus translation ----------------
    logic               v2_reg;
    logic signed [63:0] row_reg  [4];
    logic signed [65:0] sum_full [4];
    logic signed [65:0] sum_shr  [4];
    logic signed [63:0] row_next [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum_full[r] = 66'(prod_reg[r][0]) + 66'(prod_reg[r][1]) + 66'(prod_reg[r][2]);
            // arithmetic shift floors toward minus infinity
            sum_shr[r]  = sum_full[r] >>> FRAC_BITS;
            row_next[r] = sum_shr[r][63:0] + 64'(m3_reg[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
                row_reg[r] <= row_next[r];
        end
    end

    // ---------------- stage 3: divider setup ----------------
    // magnitudes, sign of result, and overflow test (quotient >= 2^32)
    logic [63:0]   den_mag;
    logic [63:0]   num_mag [3];
    logic [NW-1:0] num_sc  [3];
    logic [HW-1:0] num_hi  [3];

    logic          vd_reg   [NS+1];
    logic [63:0]   b_reg    [NS];
    logic          wz_reg   [NS+1];
    logic [63:0]   rem_reg  [NS][3];
    logic [31:0]   dq_reg   [NS+1][3];
    logic          neg_reg  [NS+1][3];
    logic          ovf_reg  [NS+1][3];

    always_comb
    begin
        den_mag = row_reg[3][63] ? (64'd0 - row_reg[3]) : row_reg[3];
        for (int l = 0; l < 3; l++)
        begin
            num_mag[l] = row_reg[l][63] ? (64'd0 - row_reg[l]) : row_reg[l];
            num_sc[l]  = {num_mag[l], {FRAC_BITS{1'b0}}};
            num_hi[l]  = num_sc[l][NW-1:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
                vd_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vd_reg[0] <= v2_reg;
            for (int k = 1; k <= NS; k++)
                vd_reg[k] <= vd_reg[k-1];
        end
    end

    // ---------------- divider stages: one quotient bit each ----------------
    logic [64:0] trial    [NS][3];
    logic        take     [NS][3];
    logic [63:0] rem_next [NS][3];
    logic [31:0] dq_next  [NS][3];

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[k][l]    = {rem_reg[k][l], dq_reg[k][l][31]};
                take[k][l]     = trial[k][l] >= {1'b0, b_reg[k]};
                rem_next[k][l] = take[k][l] ? 64'(trial[k][l] - {1'b0, b_reg[k]})
                                            : trial[k][l][63:0];
                // dividend bits leave at the top, quotient bits enter at the bottom
                dq_next[k][l]  = {dq_reg[k][l][30:0], take[k][l]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg[0]  <= den_mag;
            wz_reg[0] <= (row_reg[3] == 64'sd0);
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[0][l] <= {{(64-HW){1'b0}}, num_hi[l]};
                dq_reg[0][l]  <= num_sc[l][31:0];
                neg_reg[0][l] <= row_reg[l][63] != row_reg[3][63];
                ovf_reg[0][l] <= {{(64-HW){1'b0}}, num_hi[l]} >= den_mag;
            end
            // divisor and remainder are only needed up to the last subtract
            for (int k = 1; k < NS; k++)
            begin
                b_reg[k] <= b_reg[k-1];
                for (int l = 0; l < 3; l++)
                    rem_reg[k][l] <= rem_next[k-1][l];
            end
            for (int k = 1; k <= NS; k++)
            begin
                wz_reg[k] <= wz_reg[k-1];
                for (int l = 0; l < 3; l++)
                begin
                    dq_reg[k][l]  <= dq_next[k-1][l];
                    neg_reg[k][l] <= neg_reg[k-1][l];
                    ovf_reg[k][l] <= ovf_reg[k-1][l];
                end
            end
        end
    end

    // ---------------- final stage: sign, saturation, zero w ----------------
    logic [31:0]   coord [3];
    logic          lsat  [3];
    logic [31:0]   qv    [3];
    hpt_pkg::out_t res_next;
    hpt_pkg::out_t out_data_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            qv[l] = dq_reg[NS][l];
            if (neg_reg[NS][l])
            begin
                lsat[l]  = ovf_reg[NS][l] || (qv[l] > 32'h8000_0000);
                coord[l] = lsat[l] ? 32'h8000_0000 : (32'd0 - qv[l]);
            end
            else
            begin
                lsat[l]  = ovf_reg[NS][l] || qv[l][31];
                coord[l] = lsat[l] ? 32'h7FFF_FFFF : qv[l];
            end
        end
        if (wz_reg[NS])
        begin
            res_next = '0;
            res_next.w_zero = 1'b1;
        end
        else
        begin
            res_next.out_x     = coord[0];
            res_next.out_y     = coord[1];
            res_next.out_z     = coord[2];
            res_next.w_zero    = 1'b0;
            res_next.saturated = lsat[0] || lsat[1] || lsat[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vd_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    // a stalled output must block new transfers
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output stalled");

    // zero w gives zero coordinates and no saturation
    a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.w_zero) |->
        (out_data.out_x == 32'sd0 && out_data.out_y == 32'sd0 &&
         out_data.out_z == 32'sd0 && !out_data.saturated))
        else $error("w_zero result not clean");

    // saturation flag implies some coordinate sits at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.saturated) |->
        (out_data.out_x == 32'h7FFF_FFFF || out_data.out_x == 32'h8000_0000 ||
         out_data.out_y == 32'h7FFF_FFFF || out_data.out_y == 32'h8000_0000 ||
         out_data.out_z == 32'h7FFF_FFFF || out_data.out_z == 32'h8000_0000))
        else $error("saturated without a clamped coordinate");
`endif

endmodule

FILE: tb/tb_homogeneous_point_transform_top.sv
// testbench for the homogeneous point transform, checked against a predictor
`timescale 1ns / 1ps

// holds the matrix copy and the queue of predicted transformed points
class point_scoreboard;
    logic [63:0] matrix_regs [hpt_pkg::NUM_CFG];
    hpt_pkg::out_t predicted_q [$];
    int errors;

    function new();
        errors = 0;
        reset_matrix();
    endfunction

    function void reset_matrix();
        matrix_regs[0] = 64'd65536;
        matrix_regs[1] = 64'd0;
        matrix_regs[2] = 64'd65536 << 32;
        matrix_regs[3] = 64'd0;
        matrix_regs[4] = 64'd0;
        matrix_regs[5] = 64'd65536;
        matrix_regs[6] = 64'd0;
        matrix_regs[7] = 64'd65536 << 32;
    endfunction

    function void write_reg(int idx, logic [63:0] val);
        if (idx < hpt_pkg::NUM_CFG)
            matrix_regs[idx] = val;
    endfunction

    function logic signed [31:0] element(int r, int c);
        logic [63:0] reg_val;
        reg_val = matrix_regs[r * 2 + c / 2];
        return (c % 2) ? reg_val[63:32] : reg_val[31:0];
    endfunction

    // exact row sum, floored to the fraction bits, plus the w = 1 column
    function logic signed [127:0] row_total(int r, logic signed [31:0] px,
                                            logic signed [31:0] py, logic signed [31:0] pz);
        logic signed [127:0] acc;
        acc = 128'(element(r, 0)) * 128'(px) + 128'(element(r, 1)) * 128'(py)
            + 128'(element(r, 2)) * 128'(pz);
        acc = acc >>> hpt_pkg::FRAC_BITS;
        return acc + 128'(element(r, 3));
    endfunction

    function logic signed [31:0] quotient(logic signed [127:0] num,
                                          logic signed [127:0] den, ref bit sat);
        logic signed [127:0] q;
        q = (num <<< hpt_pkg::FRAC_BITS) / den;   // truncates toward zero
        if (q > 128'sd2147483647)
        begin
            sat = 1;
            return 32'h7fffffff;
        end
        if (q < -128'sd2147483648)
        begin
            sat = 1;
            return 32'h80000000;
        end
        return q[31:0];
    endfunction

    // note an accepted input transfer
    function void note_point(hpt_pkg::in_t p);
        hpt_pkg::out_t res;
        logic signed [127:0] sx, sy, sz, sw;
        bit sat;
        sat = 0;
        sx = row_total(0, p.in_x, p.in_y, p.in_z);
        sy = row_total(1, p.in_x, p.in_y, p.in_z);
        sz = row_total(2, p.in_x, p.in_y, p.in_z);
        sw = row_total(3, p.in_x, p.in_y, p.in_z);
        res = '0;
        if (sw == 0)
            res.w_zero = 1'b1;
        else
        begin
            res.out_x = quotient(sx, sw, sat);
            res.out_y = quotient(sy, sw, sat);
            res.out_z = quotient(sz, sw, sat);
            res.saturated = sat;
        end
        predicted_q.insert(predicted_q.size(), res);
    endfunction

    // check an accepted output transfer against the oldest prediction
    function void check_result(hpt_pkg::out_t got);
        hpt_pkg::out_t exp_res;
        if (predicted_q.size() == 0)
        begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
        end
        exp_res = predicted_q.pop_front();
        if (got.out_x !== exp_res.out_x)
            $display("%0t: out_x expected %h actual %h", $realtime, exp_res.out_x, got.out_x);
        if (got.out_y !== exp_res.out_y)
            $display("%0t: out_y expected %h actual %h", $realtime, exp_res.out_y, got.out_y);
        if (got.out_z !== exp_res.out_z)
            $display("%0t: out_z expected %h actual %h", $realtime, exp_res.out_z, got.out_z);
        if (got.w_zero !== exp_res.w_zero)
            $display("%0t: w_zero expected %b actual %b", $realtime, exp_res.w_zero, got.w_zero);
        if (got.saturated !== exp_res.saturated)
            $display("%0t: saturated expected %b actual %b", $realtime,
                     exp_res.saturated, got.saturated);
        if (got !== exp_res)
            errors++;
    endfunction
endclass

module tb_homogeneous_point_transform_top;

    localparam int PIPE_LATENCY = 3 + hpt_pkg::DIV_STEPS + 1;
    localparam int RANDOM_POINTS = 1830;
    localparam logic [63:0] ONE_Q = 64'd65536;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    hpt_pkg::in_t in_data;
    logic out_valid;
    logic out_ready;
    hpt_pkg::out_t out_data;
    logic cfg_we;
    logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hpt_pkg::CFG_W-1:0] cfg_data;

    point_scoreboard board;
    bit quiet_tail;      // no idling on either side in the last part of the run
    bit hold_output;     // requests a long receiver hold-off

    homogeneous_point_transform_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sample both transfer directions at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            board.note_point(in_data);
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_output = 0;
                out_ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 9);
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // random 32-bit value biased toward extremes and small magnitudes
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            3: return 32'($signed($urandom_range(0, 200)) - 100) << 16;
            default: return $urandom();
        endcase
    endfunction

    // offer one point, wait for the transfer, maybe idle afterward
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        hpt_pkg::in_t p;
        p.in_x = x;
        p.in_y = y;
        p.in_z = z;
        in_data <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    // let the pipeline drain before touching the matrix
    task automatic wait_drained();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (board.predicted_q.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    // one write cycle, then cfg_we drops before the next write
    task automatic write_matrix(int idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= hpt_pkg::CFG_IDX_W'(idx);
        cfg_data <= val;
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // matrix element kept modest so quotients mostly stay in range
    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
            2: return 32'h0;
            default: return 32'($signed($urandom_range(0, 65536)) - 32768);
        endcase
    endfunction

    task automatic run_points(int count);
        repeat (count)
            send_point(pick_coord(), pick_coord(), pick_coord());
    endtask

    initial
    begin
        logic [31:0] wcol;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_tail = 0;
        hold_output = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // identity: extremes pass through unchanged
        send_point(32'h7fffffff, 32'h80000000, 32'h0);
        send_point(32'h80000000, 32'h7fffffff, 32'hffffffff);
        send_point(32'h00010000, 32'hffff0000, 32'h00000001);
        wait_drained();

        // scale by 4 in x, y: saturation both ways, w stays 1
        write_matrix(0, 64'd4 * ONE_Q);
        write_matrix(2, (64'd4 * ONE_Q) << 32);
        send_point(32'h7fffffff, 32'h80000000, 32'h00010000);
        send_point(32'h00001000, 32'hfffff000, 32'h0);
        wait_drained();

        // w from z plus offset: perspective and zero-w cases
        write_matrix(6, 64'd0);
        write_matrix(7, {32'hffff0000, 32'h00010000});   // w = z - 1
        send_point(32'h00050000, 32'h00030000, 32'h00010000);   // w zero
        send_point(32'h00050000, 32'h00030000, 32'h00030000);
        send_point(32'h7fffffff, 32'h80000000, 32'h00010001);   // tiny w, saturate
        send_point(32'h00050000, 32'h00030000, 32'hfffe0000);
        wait_drained();

        // all-zero and all-ones matrices as extremes; invalid index ignored
        for (int i = 0; i < hpt_pkg::NUM_CFG; i++)
            write_matrix(i, 64'd0);
        send_point(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);   // w zero
        wait_drained();
        write_matrix(hpt_pkg::NUM_CFG + 3, 64'hffffffffffffffff);
        for (int i = 0; i < hpt_pkg::NUM_CFG; i++)
            write_matrix(i, 64'hffffffffffffffff);
        send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'h0, 32'h0, 32'h0);
        wait_drained();

        // random phases with fresh matrices; one phase sees a long output hold-off
        for (int phase = 0; phase < 6; phase++)
        begin
            for (int i = 0; i < hpt_pkg::NUM_CFG; i++)
                write_matrix(i, {pick_element(), pick_element()});
            // usually give w a translation of one to five so most points give finite quotients
            if ($urandom_range(0, 3) != 0)
            begin
                wcol = 32'($signed($urandom_range(0, 4 * 65536)) + 65536);
                write_matrix(6, {32'($signed($urandom_range(0, 64)) - 32), 32'h0});
                write_matrix(7, {wcol, 32'($signed($urandom_range(0, 64)) - 32)});
            end
            if (phase == 4)
                hold_output = 1;
            if (phase == 5)
                quiet_tail = 1;
            run_points(RANDOM_POINTS / 6);
            wait_drained();
        end

        if (board.errors == 0 && board.predicted_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: filelist.f
src/hpt_pkg.sv
src/homogeneous_point_transform_top.sv
tb/tb_homogeneous_point_transform_top.sv
